// ----- rtl/core/fmbq_pkg.sv -----
// shared constants and command codes for the front/middle/back queue
package fmbq_pkg;

    // word and count widths, default capacity and half depth
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int CNT_OUT_W   = 8;
    localparam int DEF_CAPACITY = 128;
    localparam int DEF_HALF_DEPTH = DEF_CAPACITY / 2 + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MID   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_MID    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

    // value returned when nothing was popped
    localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

endpackage

// ----- rtl/core/fmbq_ram.sv -----
// generic single-write, single-read ram with registered read data
module fmbq_ram
    import fmbq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEF_HALF_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/front_middle_back_queue_top.sv -----
// top level of the front/middle/back queue with two circular half stores
//
// Usage:
//   Input channel i_valid / o_ready carries one command word: i_cmd and
//   i_push_value. Commands push or pop at the front, the middle or the back.
//   Output channel o_valid / i_ready returns one result word per command:
//   the popped value (-1 for pushes, unused codes and empty pops), the empty
//   and full flags and the entry count after the command.
//   Steps: accept in idle, primary access, rebalance read (the popped word
//   arrives here), rebalance write only when the halves must be rebalanced,
//   then the final step registers the result; a dropped push, an empty pop
//   or an unused code skips to the final step. A new command is taken only in
//   idle, after the final step; the registered ram read serves a pop and a move.
//   Each half is a ram of CAPACITY/2+1 words; the front half keeps its
//   entries in a ring from its head, the back half likewise.
//   Reset clears heads, counts and the output valid flag; ram contents are
//   not cleared, since only written entries are ever read.
//   When the receiver stalls, the result word holds in the output register
//   and the next command may still be accepted; its result waits in the
//   final step until the output register is free.
module front_middle_back_queue_top
    import fmbq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic                     o_was_empty,
    output logic                     o_was_full,
    output logic [CNT_OUT_W-1:0]     o_entry_count
);

    localparam int HD = CAPACITY / 2 + 1;
    localparam int IW = $clog2(HD);
    localparam int CW = $clog2(HD + 1);
    localparam int TW = CW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIM,
        ST_REB,
        ST_MOVE,
        ST_FIN
    } t_state;

    // ring index helpers
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        idx_inc = (idx == IW'(HD - 1)) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx);
        idx_dec = (idx == '0) ? IW'(HD - 1) : idx - IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] head,
                                              input logic [CW-1:0] cnt);
        logic [TW-1:0] sum;
        sum = TW'(head) + TW'(cnt);
        if (sum >= TW'(HD)) begin
            sum = sum - TW'(HD);
        end
        idx_add = sum[IW-1:0];
    endfunction

    t_state                    r_state, n_state;
    logic [CMD_W-1:0]          r_cmd, n_cmd;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic [IW-1:0]             r_lhead, n_lhead, r_uhead, n_uhead;
    logic [CW-1:0]             r_lcnt, n_lcnt, r_ucnt, n_ucnt;
    logic signed [DATA_W-1:0]  r_result, n_result;
    logic                      r_empty, n_empty, r_full, n_full;
    logic                      r_pop, n_pop, r_pop_up, n_pop_up, r_mv_up, n_mv_up;
    logic                      r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]  r_out_value, n_out_value;
    logic                      r_out_empty, n_out_empty, r_out_full, n_out_full;
    logic [CNT_OUT_W-1:0]      r_out_count, n_out_count;

    logic                      l_we, u_we;
    logic [IW-1:0]             l_waddr, u_waddr, l_raddr, u_raddr;
    logic [DATA_W-1:0]         l_wdata, u_wdata, l_rdata, u_rdata;

    logic [TW-1:0]             total;
    logic [TW+CNT_OUT_W-1:0]   total_ext;
    logic                      is_push, is_pop;

    // half stores
    fmbq_ram #(.WIDTH(DATA_W), .DEPTH(HD)) u_lower (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    fmbq_ram #(.WIDTH(DATA_W), .DEPTH(HD)) u_upper (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    // occupancy and command class
    assign total     = TW'(r_lcnt) + TW'(r_ucnt);
    assign total_ext = {{CNT_OUT_W{1'b0}}, total};
    assign is_push   = (r_cmd == CMD_PUSH_FRONT) || (r_cmd == CMD_PUSH_MID) ||
                       (r_cmd == CMD_PUSH_BACK);
    assign is_pop    = (r_cmd == CMD_POP_FRONT) || (r_cmd == CMD_POP_MID) ||
                       (r_cmd == CMD_POP_BACK);

    // sequencer: primary access, rebalance read, rebalance write, result
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_lhead     = r_lhead;
        n_uhead     = r_uhead;
        n_lcnt      = r_lcnt;
        n_ucnt      = r_ucnt;
        n_result    = r_result;
        n_empty     = r_empty;
        n_full      = r_full;
        n_pop       = r_pop;
        n_pop_up    = r_pop_up;
        n_mv_up     = r_mv_up;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_out_empty = r_out_empty;
        n_out_full  = r_out_full;
        n_out_count = r_out_count;
        l_we        = 1'b0;
        u_we        = 1'b0;
        l_waddr     = '0;
        u_waddr     = '0;
        l_wdata     = r_val;
        u_wdata     = r_val;
        l_raddr     = '0;
        u_raddr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_val   = i_push_value;
                    n_state = ST_PRIM;
                end
            end

            ST_PRIM: begin
                n_result = NO_VALUE;
                n_empty  = 1'b0;
                n_full   = 1'b0;
                n_pop    = 1'b0;
                n_state  = ST_REB;
                if (is_push) begin
                    if (total >= TW'(CAPACITY)) begin
                        n_full  = 1'b1;
                        n_state = ST_FIN;
                    end else if (r_cmd == CMD_PUSH_FRONT) begin
                        n_lhead = idx_dec(r_lhead);
                        l_we    = 1'b1;
                        l_waddr = idx_dec(r_lhead);
                        n_lcnt  = r_lcnt + CW'(1);
                    end else if (r_cmd == CMD_PUSH_MID) begin
                        l_we    = 1'b1;
                        l_waddr = idx_add(r_lhead, r_lcnt);
                        n_lcnt  = r_lcnt + CW'(1);
                    end else begin
                        u_we    = 1'b1;
                        u_waddr = idx_add(r_uhead, r_ucnt);
                        n_ucnt  = r_ucnt + CW'(1);
                    end
                end else if (is_pop) begin
                    if (total == '0) begin
                        n_empty = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_pop = 1'b1;
                        priority if (r_cmd == CMD_POP_FRONT) begin
                            if (r_lcnt != '0) begin
                                n_pop_up = 1'b0;
                                l_raddr  = r_lhead;
                                n_lhead  = idx_inc(r_lhead);
                                n_lcnt   = r_lcnt - CW'(1);
                            end else begin
                                n_pop_up = 1'b1;
                                u_raddr  = r_uhead;
                                n_uhead  = idx_inc(r_uhead);
                                n_ucnt   = r_ucnt - CW'(1);
                            end
                        end else if (r_cmd == CMD_POP_MID) begin
                            if (r_ucnt > r_lcnt) begin
                                n_pop_up = 1'b1;
                                u_raddr  = r_uhead;
                                n_uhead  = idx_inc(r_uhead);
                                n_ucnt   = r_ucnt - CW'(1);
                            end else begin
                                n_pop_up = 1'b0;
                                l_raddr  = idx_add(r_lhead, r_lcnt - CW'(1));
                                n_lcnt   = r_lcnt - CW'(1);
                            end
                        end else begin
                            if (r_ucnt != '0) begin
                                n_pop_up = 1'b1;
                                u_raddr  = idx_add(r_uhead, r_ucnt - CW'(1));
                                n_ucnt   = r_ucnt - CW'(1);
                            end else begin
                                n_pop_up = 1'b0;
                                l_raddr  = idx_add(r_lhead, r_lcnt - CW'(1));
                                n_lcnt   = r_lcnt - CW'(1);
                            end
                        end
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end

            ST_REB: begin
                // popped word arrives from the read issued in the previous step
                if (r_pop) begin
                    n_result = r_pop_up ? u_rdata : l_rdata;
                end
                if (TW'(r_ucnt) == TW'(r_lcnt) + TW'(2)) begin
                    n_mv_up = 1'b1;
                    u_raddr = r_uhead;
                    n_uhead = idx_inc(r_uhead);
                    n_ucnt  = r_ucnt - CW'(1);
                    n_state = ST_MOVE;
                end else if (TW'(r_lcnt) == TW'(r_ucnt) + TW'(1)) begin
                    n_mv_up = 1'b0;
                    l_raddr = idx_add(r_lhead, r_lcnt - CW'(1));
                    n_lcnt  = r_lcnt - CW'(1);
                    n_state = ST_MOVE;
                end else begin
                    n_state = ST_FIN;
                end
            end

            ST_MOVE: begin
                // moved word lands at the middle end of the other half
                if (r_mv_up) begin
                    l_we    = 1'b1;
                    l_waddr = idx_add(r_lhead, r_lcnt);
                    l_wdata = u_rdata;
                    n_lcnt  = r_lcnt + CW'(1);
                end else begin
                    u_we    = 1'b1;
                    u_waddr = idx_dec(r_uhead);
                    u_wdata = l_rdata;
                    n_uhead = idx_dec(r_uhead);
                    n_ucnt  = r_ucnt + CW'(1);
                end
                n_state = ST_FIN;
            end

            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_result;
                    n_out_empty = r_empty;
                    n_out_full  = r_full;
                    n_out_count = total_ext[CNT_OUT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lhead     <= '0;
            r_uhead     <= '0;
            r_lcnt      <= '0;
            r_ucnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lhead     <= n_lhead;
            r_uhead     <= n_uhead;
            r_lcnt      <= n_lcnt;
            r_ucnt      <= n_ucnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_val       <= n_val;
        r_result    <= n_result;
        r_empty     <= n_empty;
        r_full      <= n_full;
        r_pop       <= n_pop;
        r_pop_up    <= n_pop_up;
        r_mv_up     <= n_mv_up;
        r_out_value <= n_out_value;
        r_out_empty <= n_out_empty;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_pop_value   = r_out_value;
    assign o_was_empty   = r_out_empty;
    assign o_was_full    = r_out_full;
    assign o_entry_count = r_out_count;

endmodule

// ----- tb/fmbq_checker.sv -----
`timescale 1ns / 100ps
// result checker for the front/middle/back queue: mirrors its contents and checks each word
module fmbq_checker
    import fmbq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic signed [DATA_W-1:0] i_pop_value,
    input  logic                     i_was_empty,
    input  logic                     i_was_full,
    input  logic [CNT_OUT_W-1:0]     i_entry_count,
    output int                       o_mismatches,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_empty_pops,
    output int                       o_full_pushes
);

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic                     was_empty;
        logic                     was_full;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_result_word;

    // mirrored contents: front half and back half of the queue
    logic signed [DATA_W-1:0] front_half[$];
    logic signed [DATA_W-1:0] back_half[$];
    t_result_word             awaited_words[$];

    int mismatch_count  = 0;
    int pending_count   = 0;
    int checked_count   = 0;
    int empty_pop_count = 0;
    int full_push_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_pending     = pending_count;
    assign o_checked     = checked_count;
    assign o_empty_pops  = empty_pop_count;
    assign o_full_pushes = full_push_count;

    // keep the back half equal to the front half or one larger
    function automatic void rebalance_halves();
        logic signed [DATA_W-1:0] moved;
        if (back_half.size() == front_half.size() + 2) begin
            moved = back_half.pop_front();
            front_half.insert(front_half.size(), moved);
        end else if (front_half.size() == back_half.size() + 1) begin
            moved = front_half[$];
            front_half.delete(front_half.size() - 1);
            back_half.push_front(moved);
        end
    endfunction

    // apply one command to the mirror and return the word it should produce
    function automatic t_result_word apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [DATA_W-1:0] value);
        t_result_word word;
        int           total;
        word.pop_value = NO_VALUE;
        word.was_empty = 1'b0;
        word.was_full  = 1'b0;
        total = front_half.size() + back_half.size();
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_MID, CMD_PUSH_BACK: begin
                if (total >= CAPACITY) begin
                    word.was_full = 1'b1;
                end else begin
                    if (cmd == CMD_PUSH_FRONT)
                        front_half.push_front(value);
                    else if (cmd == CMD_PUSH_MID)
                        front_half.insert(front_half.size(), value);
                    else
                        back_half.insert(back_half.size(), value);
                    rebalance_halves();
                end
            end
            CMD_POP_FRONT, CMD_POP_MID, CMD_POP_BACK: begin
                if (total == 0) begin
                    word.was_empty = 1'b1;
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        if (front_half.size() != 0)
                            word.pop_value = front_half.pop_front();
                        else
                            word.pop_value = back_half.pop_front();
                    end else if (cmd == CMD_POP_MID) begin
                        if (back_half.size() > front_half.size()) begin
                            word.pop_value = back_half.pop_front();
                        end else begin
                            word.pop_value = front_half[$];
                            front_half.delete(front_half.size() - 1);
                        end
                    end else begin
                        if (back_half.size() != 0) begin
                            word.pop_value = back_half[$];
                            back_half.delete(back_half.size() - 1);
                        end else begin
                            word.pop_value = front_half[$];
                            front_half.delete(front_half.size() - 1);
                        end
                    end
                    rebalance_halves();
                end
            end
            default: begin
                // unused codes leave the queue alone
            end
        endcase
        word.entry_count = CNT_OUT_W'(front_half.size() + back_half.size());
        return word;
    endfunction

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // predict on each accepted command, compare on each accepted result
    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            front_half.delete();
            back_half.delete();
            awaited_words.delete();
            pending_count = 0;
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                want = apply_command(i_cmd, i_push_value);
                if (want.was_empty)
                    empty_pop_count++;
                if (want.was_full)
                    full_push_count++;
                awaited_words.insert(awaited_words.size(), want);
                pending_count++;
            end
            if (i_res_valid && i_res_ready) begin
                if (awaited_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with none expected, pop_value %0d count %0d",
                             $time, i_pop_value, i_entry_count);
                end else begin
                    want = awaited_words.pop_front();
                    pending_count--;
                    checked_count++;
                    compare_field("pop_value", longint'(want.pop_value), longint'(i_pop_value));
                    compare_field("was_empty", longint'(want.was_empty), longint'(i_was_empty));
                    compare_field("was_full", longint'(want.was_full), longint'(i_was_full));
                    compare_field("entry_count", longint'(want.entry_count),
                                  longint'(i_entry_count));
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the front/middle/back queue: clock, reset, stimulus and verdict
module tb_top;
    import fmbq_pkg::*;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_traffic_mix;

    localparam int RANDOM_WORDS = 1950;
    localparam int IDLE_PCT     = 11;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 800;
    localparam int STALL_AT     = 1200;
    localparam int STALL_CYCLES = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_POP_BACK + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = CMD_POP_BACK + 3'd2;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_cmd        = CMD_PUSH_FRONT;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_valid;
    logic                     i_ready      = 1'b0;
    logic signed [DATA_W-1:0] o_pop_value;
    logic                     o_was_empty;
    logic                     o_was_full;
    logic [CNT_OUT_W-1:0]     o_entry_count;

    int words_sent = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    int mismatches;
    int pending;
    int checked;
    int empty_pops;
    int full_pushes;

    front_middle_back_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pop_value   (o_pop_value),
        .o_was_empty   (o_was_empty),
        .o_was_full    (o_was_full),
        .o_entry_count (o_entry_count)
    );

    fmbq_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_ready   (o_ready),
        .i_cmd         (i_cmd),
        .i_push_value  (i_push_value),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_pop_value   (o_pop_value),
        .i_was_empty   (o_was_empty),
        .i_was_full    (o_was_full),
        .i_entry_count (o_entry_count),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_empty_pops  (empty_pops),
        .o_full_pushes (full_pushes)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit in_calm_stretch();
        return words_sent >= CALM_FIRST && words_sent < CALM_LAST;
    endfunction

    // result side: random stalls, one long hold-off to back up the queue
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!stall_done && words_sent >= STALL_AT) begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            i_ready    <= 1'b0;
        end else if (in_calm_stretch()) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one command word, with an occasional gap before it
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value);
        if (!in_calm_stretch() && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // push values lean toward the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return -32'sd1;
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(input t_traffic_mix mix);
        int roll;
        int push_pct;
        roll     = $urandom_range(99);
        push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 13 : 49;
        if (roll < 2)
            return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (roll < 2 + push_pct)
            return CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_BACK));
        else
            return CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK));
    endfunction

    task automatic run_mix(input t_traffic_mix mix, input int count, inout int sent_random);
        for (int n = 0; n < count && sent_random < RANDOM_WORDS; n++) begin
            send_word(pick_cmd(mix), pick_value());
            sent_random++;
        end
    endtask

    // stimulus
    initial begin
        int           sent_random;
        int           directed_words;
        t_traffic_mix mix;
        sent_random = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops and unused codes on an empty queue
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_MID, $urandom);
        send_word(CMD_POP_BACK, $urandom);
        send_word(CMD_UNUSED_LO, $urandom);
        send_word(CMD_UNUSED_HI, $urandom);
        // every push with extreme values
        send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
        send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_word(CMD_PUSH_MID, '0);
        send_word(CMD_PUSH_MID, -32'sd1);
        send_word(CMD_PUSH_BACK, 32'sd1);
        send_word(CMD_PUSH_FRONT, 32'sh5555_5555);
        send_word(CMD_PUSH_MID, 32'shAAAA_AAAA);
        // every pop, unused code on a loaded queue, drain to empty
        send_word(CMD_POP_MID, $urandom);
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_BACK, $urandom);
        send_word(CMD_UNUSED_HI, $urandom);
        send_word(CMD_POP_MID, $urandom);
        send_word(CMD_POP_MID, $urandom);
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_BACK, $urandom);
        send_word(CMD_POP_BACK, $urandom);
        directed_words = words_sent;

        // fill past full, drain past empty, then mixed phases
        run_mix(MIX_FILL, 260, sent_random);
        run_mix(MIX_DRAIN, 260, sent_random);
        while (sent_random < RANDOM_WORDS) begin
            mix = t_traffic_mix'($urandom_range(MIX_FILL, MIX_EVEN));
            run_mix(mix, $urandom_range(40, 250), sent_random);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d command words (%0d directed), checked %0d result words",
                 words_sent, directed_words, checked);
        $display("pops on an empty queue: %0d, pushes dropped on a full queue: %0d",
                 empty_pops, full_pushes);
        if (mismatches == 0) begin
            $display("front_middle_back_queue_top test passed");
        end else begin
            $display("front_middle_back_queue_top test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("front_middle_back_queue_top test failed");
        $finish;
    end

endmodule
